/* rtl/assert_macros.svh */
// Assertion macros for the top level of the level encoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define ALME_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alme: implication check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define ALME_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alme: next-cycle check failed");
`else
`define ALME_ASSERT_IMP(name, ante, cons)
`define ALME_ASSERT_NEXT(name, ante, cons)
`endif
`endif

/* rtl/alme_pkg.sv */
// Shared types, constants and SPI triplet encoder for the level encoder
`default_nettype none
package alme_pkg;

  localparam int HistDepth = 8;
  localparam int SumCnt    = 6;
  localparam int LedLast   = 63;

  localparam logic [15:0] MarkFull = 16'h4924;
  localparam logic [15:0] MarkLast = 16'h4920;

  typedef logic [3:0]  level_t;
  typedef logic [2:0]  hist_addr_t;
  typedef logic [6:0]  sum_t;
  typedef logic [5:0]  led_idx_t;
  typedef logic [23:0] grb_t;
  typedef logic [4:0][15:0] spi_words_t;

  // Control from the sequencer to the level history
  typedef struct packed {
    logic       push;
    level_t     level;
    hist_addr_t rd_addr;
  } hist_ctl_t;

  // Each colour bit d becomes triplet 1,d,0; five triplets per word from bit 14, last triplet of word 4 zero
  function automatic spi_words_t encode_grb(input grb_t grb);
    spi_words_t words;
    logic [15:0] word;
    int          pos;
    for (int w = 0; w < 5; w++) begin
      word = (w == 4) ? MarkLast : MarkFull;
      for (int k = 0; k < 5; k++) begin
        pos = 23 - 5 * w - k;
        if (pos >= 0) begin
          word[13 - 3 * k] = grb[pos];
        end
      end
      words[w] = word;
    end
    return words;
  endfunction

endpackage
`default_nettype wire

/* rtl/alme_hist.sv */
// Eight-entry level history with a single read port
`default_nettype none
module alme_hist (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire alme_pkg::hist_ctl_t ctl,
  output alme_pkg::level_t        rd_level
);
  import alme_pkg::*;

  level_t lvl_r [HistDepth];

  // newest level enters at entry 0, oldest drops off the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HistDepth; i++) lvl_r[i] <= '0;
    end else if (ctl.push) begin
      lvl_r[0] <= ctl.level;
      for (int i = 1; i < HistDepth; i++) lvl_r[i] <= lvl_r[i - 1];
    end
  end

  assign rd_level = lvl_r[ctl.rd_addr];

endmodule
`default_nettype wire

/* rtl/alme_pixel.sv */
// Per-LED colour unit: bar or glow colour, then SPI triplet packing
`default_nettype none
module alme_pixel (
  input  wire logic              mode,
  input  wire alme_pkg::led_idx_t idx,
  input  wire alme_pkg::level_t  level,
  input  wire alme_pkg::sum_t    sum,
  output alme_pkg::spi_words_t   words
);
  import alme_pkg::*;

  logic [2:0] row;
  logic [2:0] cm;       // column after serpentine mirroring
  logic [2:0] col;
  logic       lit;
  logic [7:0] red_bar;
  logic [7:0] grn_bar;
  logic [5:0] csq;
  logic [5:0] rsq;
  logic [6:0] dsq;
  logic [8:0] gain;
  logic [9:0] v;
  logic [7:0] red_glow;
  logic [7:0] red;
  logic [7:0] grn;

  assign row = idx[5:3];
  assign cm  = row[0] ? ~idx[2:0] : idx[2:0];
  assign col = ~cm;

  // bar mode: lit when the row's level reaches the column
  assign lit     = (level >= {1'b0, col});
  assign red_bar = lit ? 8'd64 : 8'd0;
  assign grn_bar = lit ? (8'd1 << cm) : 8'd0;

  // glow mode: 4*sum - 2*(c^2 + y^2), clamped to a byte
  assign csq  = {3'b000, cm} * {3'b000, cm};
  assign rsq  = {3'b000, row} * {3'b000, row};
  assign dsq  = {1'b0, csq} + {1'b0, rsq};
  assign gain = {sum, 2'b00};
  assign v    = {1'b0, gain} - {2'b00, dsq, 1'b0};

  always_comb begin
    if (v[9]) begin
      red_glow = 8'd0;
    end else if (v[8]) begin
      red_glow = 8'd255;
    end else begin
      red_glow = v[7:0];
    end
  end

  assign red = mode ? red_glow : red_bar;
  assign grn = mode ? {2'b00, red_glow[7:2]} : grn_bar;

  assign words = encode_grb({grn, red, 8'h00});

endmodule
`default_nettype wire

/* rtl/audio_level_led_matrix_encoder_core.sv */
// Top level: sequencer, config register and result register of the encoder
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_audio_sample
//  out     | output    | out_valid/out_stall | out_led_index, out_spi_word0..4,
//          |           |                     | out_frame_last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_led_mode
//
// One request gives 64 results: the request is taken, the adder sums six levels
// from the history, then one LED per cycle goes through the colour unit unless
// the out channel stalls. A stall on the out channel holds the LED walk.
// Synchronous active-low reset clears the levels, the mode and the sequencer.
// in_stall stays high from acceptance until the last LED has been loaded.
`default_nettype none
`include "assert_macros.svh"
module audio_level_led_matrix_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_audio_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_led_index,
  output logic [15:0]      out_spi_word0,
  output logic [15:0]      out_spi_word1,
  output logic [15:0]      out_spi_word2,
  output logic [15:0]      out_spi_word3,
  output logic [15:0]      out_spi_word4,
  output logic             out_frame_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_led_mode
);
  import alme_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_LED
  } state_t;

  state_t     state_r;
  hist_addr_t cnt_r;
  sum_t       sum_r;
  led_idx_t   idx_r;
  logic       mode_r;
  logic       out_valid_r;
  led_idx_t   out_idx_r;
  spi_words_t out_words_r;
  logic       out_last_r;

  hist_ctl_t  hctl;
  level_t     rd_level;
  spi_words_t pix_words;
  logic       in_acc;
  logic       out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // history control: push on request, read by sum counter or LED row
  assign hctl.push    = in_acc;
  assign hctl.level   = in_audio_sample[15:12];
  assign hctl.rd_addr = (state_r == ST_SUM) ? cnt_r : idx_r[5:3];

  alme_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hctl),
    .rd_level (rd_level)
  );

  alme_pixel u_pixel (
    .mode  (mode_r),
    .idx   (idx_r),
    .level (rd_level),
    .sum   (sum_r),
    .words (pix_words)
  );

  // sequencer, mode register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_led_mode;
      end

      // result register refills during the LED walk, else empties once taken
      if (out_free) begin
        out_valid_r <= (state_r == ST_LED);
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cnt_r   <= '0;
            sum_r   <= '0;
            idx_r   <= '0;
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_r <= sum_r + {3'b000, rd_level};
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'(SumCnt - 1)) begin
            state_r <= ST_LED;
          end
        end
        ST_LED: begin
          if (out_free) begin
            out_idx_r   <= idx_r;
            out_words_r <= pix_words;
            out_last_r  <= (idx_r == 6'(LedLast));
            idx_r       <= idx_r + 6'd1;
            if (idx_r == 6'(LedLast)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_index  = out_idx_r;
  assign out_spi_word0  = out_words_r[0];
  assign out_spi_word1  = out_words_r[1];
  assign out_spi_word2  = out_words_r[2];
  assign out_spi_word3  = out_words_r[3];
  assign out_spi_word4  = out_words_r[4];
  assign out_frame_last = out_last_r;

  // checks on the sequencer
  `ALME_ASSERT_IMP(a_last_is_63, out_valid && out_frame_last, out_led_index == 6'(LedLast))
  `ALME_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall && sum_r == '0)
  `ALME_ASSERT_IMP(a_idle_idx_zero, !in_stall, idx_r == '0)

endmodule
`default_nettype wire
